[rtl/core/cncc_pkg.sv]
`default_nettype none
package cncc_pkg;

  // Default configuration of the classifier.
  localparam int NUM_CATEGORIES_DEF = 12;
  localparam int NUM_DAYS_DEF       = 7;
  localparam int COUNT_FIELDS       = 7;

  // Port widths fixed by the item format.
  localparam int FUNC_W  = 1;
  localparam int CAT_W   = 4;
  localparam int DAY_W   = 3;
  localparam int VALUE_W = 24;
  localparam int COUNT_W = 16;
  localparam int SIM_W   = 16;

  // Datapath widths, sized for up to eight days.
  localparam int LIMB_W = 24;
  localparam int PROD_W = 2 * LIMB_W;
  localparam int DOT_W  = 43;
  localparam int NA_W   = 35;
  localparam int NB_W   = 51;
  localparam int NUM_W  = 86;
  localparam int DEN_W  = 86;
  localparam int QSH    = 30;
  localparam int REM_W  = NUM_W + QSH;
  localparam int Q_W    = QSH + 1;
  localparam int IDX_W  = 5;

  localparam logic [FUNC_W-1:0] FUNC_LOAD     = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_CLASSIFY = 1'b1;

  localparam logic [SIM_W-1:0] SIM_ONE = 16'd32768;

  // Pairs of limbs for the two wide products.
  localparam logic [IDX_W-1:0] NUM_PAIRS  = 5'd4;
  localparam logic [IDX_W-1:0] LAST_PAIR  = 5'd9;
  localparam logic [IDX_W-1:0] LAST_QBIT  = 5'd30;
  localparam logic [IDX_W-1:0] LAST_SBIT  = 5'd15;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_NA   = 11'b00000000010,
    S_CAT  = 11'b00000000100,
    S_MAC  = 11'b00000001000,
    S_ZCHK = 11'b00000010000,
    S_PROD = 11'b00000100000,
    S_DSET = 11'b00001000000,
    S_DIV  = 11'b00010000000,
    S_SQRT = 11'b00100000000,
    S_PICK = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

endpackage
`default_nettype wire

[rtl/core/cncc_mem.sv]
`default_nettype none
module cncc_mem
  import cncc_pkg::*;
#(
  parameter int DEPTH = NUM_CATEGORIES_DEF * NUM_DAYS_DEF,
  parameter int AW    = $clog2(NUM_CATEGORIES_DEF * NUM_DAYS_DEF)
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [AW-1:0]      waddr,
  input  wire logic [VALUE_W-1:0] wdata,
  input  wire logic               re,
  input  wire logic [AW-1:0]      raddr,
  output logic      [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/cncc_mul.sv]
`default_nettype none
module cncc_mul
  import cncc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [LIMB_W-1:0] a,
  input  wire logic [LIMB_W-1:0] b,
  output logic      [PROD_W-1:0] p
);

  // Registered unsigned product; the result is ready in the cycle after its operands.
  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule
`default_nettype wire

[rtl/core/cosine_nearest_centroid_classifier.sv]
`default_nettype none
// Cosine nearest-centroid classifier. A load transfer (func = 0) writes one
// Q16.8 centroid element into the table and marks its category loaded; loads
// outside the table are ignored and give no result. A classify transfer
// (func = 1) returns one result: the loaded category whose centroid has the
// highest cosine similarity to the seven daily counts, that similarity as
// floor(32768 * cosine) in Q1.15, a flag when it differs from prev_category,
// and no_category when nothing is loaded. A classify runs on one registered
// 24 x 24 multiplier under a sequencer. It first forms the count norm, then
// tests the loaded flag of each category in turn. Each loaded category then
// goes through multiply-accumulate and zero test, limb products, restoring
// division, square root search and a compare of its similarity with the
// best so far. A category with a zero norm skips the products, the division
// and the square root. A last step moves the result into the output
// register. The block takes no input while a classify is in progress, nor
// during reset. The result sits in an output register until it is taken; a
// classify that finishes while an earlier result is still waiting holds in
// its last step until that result has been taken.
module cosine_nearest_centroid_classifier
  import cncc_pkg::*;
#(
  parameter int NUM_CATEGORIES = NUM_CATEGORIES_DEF,
  parameter int NUM_DAYS       = NUM_DAYS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [FUNC_W-1:0]  func,
  input  wire logic [CAT_W-1:0]   category,
  input  wire logic [DAY_W-1:0]   day,
  input  wire logic [VALUE_W-1:0] centroid_value,
  input  wire logic [COUNT_W-1:0] count_0,
  input  wire logic [COUNT_W-1:0] count_1,
  input  wire logic [COUNT_W-1:0] count_2,
  input  wire logic [COUNT_W-1:0] count_3,
  input  wire logic [COUNT_W-1:0] count_4,
  input  wire logic [COUNT_W-1:0] count_5,
  input  wire logic [COUNT_W-1:0] count_6,
  input  wire logic [CAT_W-1:0]   prev_category,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [CAT_W-1:0]        best_category,
  output logic [SIM_W-1:0]        best_similarity,
  output logic                    changed,
  output logic                    no_category
);

  localparam int DEPTH = NUM_CATEGORIES * NUM_DAYS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(NUM_CATEGORIES);
  localparam int DW    = (NUM_DAYS > 1) ? $clog2(NUM_DAYS) : 1;
  // Wide enough to compare category and day inputs against the limits.
  localparam int LW    = 8;

  localparam logic [CW-1:0]    LAST_CAT = CW'(NUM_CATEGORIES - 1);
  localparam logic [IDX_W-1:0] LAST_DAY = IDX_W'(NUM_DAYS - 1);

  state_t state;
  logic [1:0]          ph;
  logic [IDX_W-1:0]    idx;
  logic [CW-1:0]       cat;
  logic [NUM_CATEGORIES-1:0] loaded;
  logic [COUNT_W-1:0]  cnt [NUM_DAYS];
  logic [CAT_W-1:0]    prev;
  logic [NA_W-1:0]     na;
  logic [DOT_W-1:0]    dot;
  logic [NB_W-1:0]     nb;
  logic [NUM_W-1:0]    num;
  logic [DEN_W-1:0]    den;
  logic [REM_W-1:0]    rem;
  logic [REM_W-1:0]    dsh;
  logic [Q_W-1:0]      q;
  logic [SIM_W-1:0]    s;
  logic [SIM_W-1:0]    sim;
  logic [SIM_W-1:0]    best_sim;
  logic [CW-1:0]       best_cat;
  logic                found;

  logic [COUNT_W-1:0]  in_cnt [COUNT_FIELDS];
  logic                accept;
  logic                load_ok;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic                mem_re;
  logic [VALUE_W-1:0]  v;
  logic [LIMB_W-1:0]   mul_a;
  logic [LIMB_W-1:0]   mul_b;
  logic [PROD_W-1:0]   prod;
  logic [COUNT_W-1:0]  cur_cnt;
  logic [1:0]          pi;
  logic [1:0]          pj;
  logic                pair_num;
  logic [NUM_W-1:0]    shifted;
  logic [SIM_W-1:0]    trial;

  assign in_cnt[0] = count_0;
  assign in_cnt[1] = count_1;
  assign in_cnt[2] = count_2;
  assign in_cnt[3] = count_3;
  assign in_cnt[4] = count_4;
  assign in_cnt[5] = count_5;
  assign in_cnt[6] = count_6;

  assign in_ready = (state == S_IDLE) && !rst;
  assign accept   = in_valid && in_ready;
  assign load_ok  = accept && (func == FUNC_LOAD)
                    && (LW'(category) < LW'(NUM_CATEGORIES))
                    && (LW'(day) < LW'(NUM_DAYS));
  assign waddr    = AW'(int'(category) * NUM_DAYS + int'(day));
  assign raddr    = AW'(int'(cat) * NUM_DAYS + int'(idx[DW-1:0]));
  assign mem_re   = (state == S_MAC) && (ph == 2'd0);
  assign cur_cnt  = cnt[idx[DW-1:0]];
  assign trial    = s | (SIM_W'(1) << idx[3:0]);

  cncc_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (load_ok),
    .waddr (waddr),
    .wdata (centroid_value),
    .re    (mem_re),
    .raddr (raddr),
    .rdata (v)
  );

  cncc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Limb pairs: the first four build dot squared, the next six the
  // product of the two norms.
  always_comb begin
    pair_num = (idx < NUM_PAIRS);
    pi = 2'd0;
    pj = 2'd0;
    case (idx)
      5'd0: begin pi = 2'd0; pj = 2'd0; end
      5'd1: begin pi = 2'd0; pj = 2'd1; end
      5'd2: begin pi = 2'd1; pj = 2'd0; end
      5'd3: begin pi = 2'd1; pj = 2'd1; end
      5'd4: begin pi = 2'd0; pj = 2'd0; end
      5'd5: begin pi = 2'd0; pj = 2'd1; end
      5'd6: begin pi = 2'd0; pj = 2'd2; end
      5'd7: begin pi = 2'd1; pj = 2'd0; end
      5'd8: begin pi = 2'd1; pj = 2'd1; end
      5'd9: begin pi = 2'd1; pj = 2'd2; end
      default: begin pi = 2'd0; pj = 2'd0; end
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_NA: begin
        mul_a = LIMB_W'(cur_cnt);
        mul_b = LIMB_W'(cur_cnt);
      end
      S_MAC: begin
        if (ph == 2'd1) begin
          mul_a = LIMB_W'(cur_cnt);
          mul_b = v;
        end else begin
          mul_a = v;
          mul_b = v;
        end
      end
      S_PROD: begin
        if (pair_num) begin
          mul_a = (pi == 2'd0) ? dot[LIMB_W-1:0] : LIMB_W'(dot[DOT_W-1:LIMB_W]);
          mul_b = (pj == 2'd0) ? dot[LIMB_W-1:0] : LIMB_W'(dot[DOT_W-1:LIMB_W]);
        end else begin
          mul_a = (pi == 2'd0) ? na[LIMB_W-1:0] : LIMB_W'(na[NA_W-1:LIMB_W]);
          case (pj)
            2'd0:    mul_b = nb[LIMB_W-1:0];
            2'd1:    mul_b = nb[2*LIMB_W-1:LIMB_W];
            default: mul_b = LIMB_W'(nb[NB_W-1:2*LIMB_W]);
          endcase
        end
      end
      S_SQRT: begin
        mul_a = LIMB_W'(trial);
        mul_b = LIMB_W'(trial);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (2'(pi + pj))
      2'd0:    shifted = NUM_W'(prod);
      2'd1:    shifted = NUM_W'(prod) << LIMB_W;
      2'd2:    shifted = NUM_W'(prod) << (2 * LIMB_W);
      default: shifted = NUM_W'(prod) << (3 * LIMB_W);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ph        <= '0;
      idx       <= '0;
      cat       <= '0;
      loaded    <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (load_ok) begin
            loaded[CW'(category)] <= 1'b1;
          end
          if (accept && (func == FUNC_CLASSIFY)) begin
            for (int d = 0; d < NUM_DAYS; d++) begin
              cnt[d] <= (d < COUNT_FIELDS) ? in_cnt[d % COUNT_FIELDS] : '0;
            end
            prev  <= prev_category;
            na    <= '0;
            idx   <= '0;
            ph    <= '0;
            cat   <= '0;
            found <= 1'b0;
            state <= S_NA;
          end
        end
        S_NA: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else begin
            na <= na + NA_W'(prod);
            ph <= 2'd0;
            if (idx == LAST_DAY) begin
              state <= S_CAT;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_CAT: begin
          if (loaded[cat]) begin
            dot   <= '0;
            nb    <= '0;
            idx   <= '0;
            ph    <= '0;
            state <= S_MAC;
          end else if (cat == LAST_CAT) begin
            state <= S_OUT;
          end else begin
            cat <= cat + 1'b1;
          end
        end
        S_MAC: begin
          ph <= ph + 1'b1;
          if (ph == 2'd2) begin
            dot <= dot + DOT_W'(prod);
          end
          if (ph == 2'd3) begin
            nb <= nb + NB_W'(prod);
            if (idx == LAST_DAY) begin
              state <= S_ZCHK;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_ZCHK: begin
          idx <= '0;
          ph  <= '0;
          num <= '0;
          den <= '0;
          if ((na == '0) || (nb == '0)) begin
            sim   <= '0;
            state <= S_PICK;
          end else begin
            state <= S_PROD;
          end
        end
        S_PROD: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else begin
            ph <= 2'd0;
            if (pair_num) begin
              num <= num + shifted;
            end else begin
              den <= den + DEN_W'(shifted);
            end
            if (idx == LAST_PAIR) begin
              state <= S_DSET;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_DSET: begin
          rem   <= {num, QSH'(0)};
          dsh   <= {den, QSH'(0)};
          q     <= '0;
          idx   <= LAST_QBIT;
          state <= S_DIV;
        end
        S_DIV: begin
          // Restoring division: one quotient bit a cycle, most significant
          // first, against the divisor shifted into place.
          if (rem >= dsh) begin
            rem      <= rem - dsh;
            q[idx]   <= 1'b1;
          end
          dsh <= dsh >> 1;
          if (idx == '0) begin
            s     <= '0;
            ph    <= '0;
            idx   <= LAST_SBIT;
            state <= S_SQRT;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        S_SQRT: begin
          // Integer square root by bitwise search, squaring each trial.
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else begin
            ph <= 2'd0;
            if (prod <= PROD_W'(q)) begin
              s <= trial;
            end
            if (idx == '0) begin
              state <= S_PICK;
            end else begin
              idx <= idx - 1'b1;
            end
          end
        end
        S_PICK: begin
          if (!found || (sim > best_sim)) begin
            found    <= 1'b1;
            best_sim <= sim;
            best_cat <= cat;
          end
          if (cat == LAST_CAT) begin
            state <= S_OUT;
          end else begin
            cat   <= cat + 1'b1;
            state <= S_CAT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            no_category     <= !found;
            best_category   <= found ? CAT_W'(best_cat) : '0;
            best_similarity <= found ? best_sim : '0;
            changed         <= found && (LW'(best_cat) != LW'(prev));
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // The square root result enters the similarity as it settles.
      if ((state == S_SQRT) && (ph == 2'd1) && (idx == '0)) begin
        if (prod <= PROD_W'(q)) begin
          sim <= (trial > SIM_ONE) ? SIM_ONE : trial;
        end else begin
          sim <= (s > SIM_ONE) ? SIM_ONE : s;
        end
      end
    end
  end

endmodule
`default_nettype wire

[tb/cosine_nearest_centroid_classifier_test.sv]
`timescale 1ns / 1ps
module cosine_nearest_centroid_classifier_test;
  import cncc_pkg::*;

  localparam int CATS = NUM_CATEGORIES_DEF;
  localparam int DAYS = NUM_DAYS_DEF;

  // One item as it is presented on the input channel.
  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [CAT_W-1:0]   category;
    logic [DAY_W-1:0]   day;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] counts [COUNT_FIELDS];
    logic [CAT_W-1:0]   prev;
  } request_t;

  // One classification outcome, as the output channel should present it.
  typedef struct {
    logic [CAT_W-1:0] cat;
    logic [SIM_W-1:0] sim;
    logic             chg;
    logic             none;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CAT_W-1:0] best_category;
  logic [SIM_W-1:0] best_similarity;
  logic changed;
  logic no_category;

  request_t pending_requests [$];
  verdict_t expected_verdicts [$];
  request_t req_now;
  int cycle_count = 0;
  int mismatch_count = 0;

  // The predictor's own copy of the centroid table and its loaded flags.
  logic [VALUE_W-1:0] profile_table [CATS][DAYS];
  logic [CATS-1:0]    profile_loaded;

  // Generator-side record of which categories have been loaded, so that
  // a classify never reads an element of a category that was never written.
  logic [CATS-1:0] gen_loaded;

  always #1 clk = ~clk;

  initial begin
    foreach (req_now.counts[i]) req_now.counts[i] = '0;
    req_now.func = FUNC_LOAD;
    req_now.category = '0;
    req_now.day = '0;
    req_now.value = '0;
    req_now.prev = '0;
  end

  cosine_nearest_centroid_classifier dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(req_now.func), .category(req_now.category), .day(req_now.day),
    .centroid_value(req_now.value),
    .count_0(req_now.counts[0]), .count_1(req_now.counts[1]),
    .count_2(req_now.counts[2]), .count_3(req_now.counts[3]),
    .count_4(req_now.counts[4]), .count_5(req_now.counts[5]),
    .count_6(req_now.counts[6]),
    .prev_category(req_now.prev),
    .out_valid(out_valid), .out_ready(out_ready),
    .best_category(best_category), .best_similarity(best_similarity),
    .changed(changed), .no_category(no_category)
  );

  // Quantised cosine: the largest s with s*s*normA*normB <= 2^30*dot*dot,
  // found one bit at a time from the top and clipped at one in Q1.15.
  function automatic logic [SIM_W-1:0] cosine_q15(logic [127:0] dot,
                                                   logic [127:0] norm_counts,
                                                   logic [127:0] norm_profile);
    logic [127:0] den;
    logic [127:0] num;
    logic [127:0] trial;
    logic [31:0]  s;
    s = '0;
    if (norm_counts == 0 || norm_profile == 0) return '0;
    den = norm_counts * norm_profile;
    num = (dot * dot) << 30;
    for (int b = 15; b >= 0; b--) begin
      trial = 128'(s | (32'd1 << b));
      if (den * trial * trial <= num) s = 32'(trial);
    end
    return (s > 32'd32768) ? SIM_ONE : s[SIM_W-1:0];
  endfunction

  // Applies one transferred item to the predictor; a classify leaves its
  // expected verdict at the back of the queue.
  task automatic apply_request(request_t r);
    logic [127:0] norm_counts;
    logic [127:0] dot;
    logic [127:0] norm_profile;
    logic [SIM_W-1:0] sim;
    verdict_t v;
    logic found;
    norm_counts = '0;
    found = 1'b0;
    v = '{cat: '0, sim: '0, chg: 1'b0, none: 1'b1};
    if (r.func == FUNC_LOAD) begin
      if (r.category < CATS && r.day < DAYS) begin
        profile_table[r.category][r.day] = r.value;
        profile_loaded[r.category] = 1'b1;
      end
      return;
    end
    for (int d = 0; d < DAYS; d++)
      norm_counts += 128'(r.counts[d]) * 128'(r.counts[d]);
    for (int c = 0; c < CATS; c++) begin
      if (profile_loaded[c]) begin
        dot = '0;
        norm_profile = '0;
        for (int d = 0; d < DAYS; d++) begin
          dot += 128'(r.counts[d]) * 128'(profile_table[c][d]);
          norm_profile += 128'(profile_table[c][d]) * 128'(profile_table[c][d]);
        end
        sim = cosine_q15(dot, norm_counts, norm_profile);
        // A strict comparison keeps the lowest index when similarities tie.
        if (!found || sim > v.sim) begin
          found = 1'b1;
          v.sim = sim;
          v.cat = CAT_W'(c);
        end
      end
    end
    if (found) begin
      v.none = 1'b0;
      v.chg = (v.cat != r.prev);
    end
    expected_verdicts = {expected_verdicts, v};
  endtask

  // A long stretch in the middle of the run has no idling on either side.
  function automatic logic take_a_break();
    if (cycle_count > 60000 && cycle_count < 160000) return 1'b0;
    return $urandom_range(0, 99) < 26;
  endfunction

  // Driver: a new item is offered only when the channel is free or the
  // current item is being transferred at this edge, so valid is assigned
  // once per edge and never dropped before its transfer.
  always @(posedge clk) begin
    logic next_valid;
    next_valid = in_valid;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) apply_request(req_now);
      next_valid = 1'b0;
      if (pending_requests.size() > 0 && !take_a_break()) begin
        req_now <= pending_requests.pop_front();
        next_valid = 1'b1;
      end
      in_valid <= next_valid;
    end
  end

  // Monitor: every transfer on the output channel is checked against the
  // oldest expected verdict.
  always @(posedge clk) begin
    verdict_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: cat %0d sim %0d chg %0b none %0b",
                     best_category, best_similarity, changed, no_category);
        end else begin
          e = expected_verdicts.pop_front();
          if (best_category !== e.cat || best_similarity !== e.sim ||
              changed !== e.chg || no_category !== e.none) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected cat %0d sim %0d chg %0b none %0b,",
                       e.cat, e.sim, e.chg, e.none,
                       " got cat %0d sim %0d chg %0b none %0b",
                       best_category, best_similarity, changed, no_category);
          end
        end
      end
      out_ready <= !take_a_break();
    end
  end

  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return COUNT_W'($urandom_range(0, 15));
      default: return COUNT_W'($urandom);
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return VALUE_W'($urandom_range(0, 4095));
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic queue_load(int cat, int d, logic [VALUE_W-1:0] val);
    request_t r;
    r = req_now;
    r.func = FUNC_LOAD;
    r.category = CAT_W'(cat);
    r.day = DAY_W'(d);
    r.value = val;
    foreach (r.counts[i]) r.counts[i] = COUNT_W'($urandom);
    r.prev = CAT_W'($urandom);
    if (cat < CATS && d < DAYS) gen_loaded[cat] = 1'b1;
    pending_requests = {pending_requests, r};
  endtask

  task automatic queue_classify(logic [COUNT_W-1:0] fill, int mode, int prev);
    request_t r;
    r = req_now;
    r.func = FUNC_CLASSIFY;
    r.category = CAT_W'($urandom);
    r.day = DAY_W'($urandom);
    r.value = VALUE_W'($urandom);
    foreach (r.counts[i]) r.counts[i] = (mode == 0) ? fill : pick_count();
    r.prev = CAT_W'(prev);
    pending_requests = {pending_requests, r};
  endtask

  // A whole category at once, so that no loaded category has holes.
  task automatic queue_profile(int cat, int zero);
    for (int d = 0; d < DAYS; d++) queue_load(cat, d, zero ? '0 : pick_value());
  endtask

  initial begin
    int items;
    int pick;
    int cat;
    logic [VALUE_W-1:0] v;
    items = 0;
    gen_loaded = '0;
    profile_loaded = '0;
    foreach (profile_table[c, d]) profile_table[c][d] = '0;

    // Directed part: nothing loaded, loads outside the table, extremes of
    // the centroid values and counts, a tie, and a previous category that
    // lies outside the table.
    queue_classify('1, 0, 3);
    queue_load(13, 2, '1);
    queue_load(4, 7, '1);
    queue_classify(16'd7, 0, 0);
    for (int d = 0; d < DAYS; d++) begin
      v = (d % 2) ? '1 : VALUE_W'(d);
      queue_load(5, d, v);
      queue_load(11, d, v);
    end
    queue_classify('0, 0, 5);
    queue_classify('1, 0, 15);
    queue_classify('1, 0, 5);
    queue_classify(16'd1, 1, 11);
    items = pending_requests.size();

    // Random part: mostly loads into categories that are already whole,
    // new or rewritten categories as full bursts, a share of loads that
    // fall outside the table, and classifies in between.
    while (items < 1700) begin
      pick = $urandom_range(0, 99);
      if (pick < 8 || gen_loaded == '0) begin
        queue_profile($urandom_range(0, CATS - 1), $urandom_range(0, 15) == 0);
        items += DAYS;
      end else if (pick < 14) begin
        if ($urandom_range(0, 1)) queue_load($urandom_range(CATS, 15),
                                             $urandom_range(0, 7), pick_value());
        else queue_load($urandom_range(0, CATS - 1), 7, pick_value());
        items++;
      end else if (pick < 78) begin
        do cat = $urandom_range(0, CATS - 1); while (!gen_loaded[cat]);
        queue_load(cat, $urandom_range(0, DAYS - 1), pick_value());
        items++;
      end else begin
        queue_classify('0, 1, $urandom_range(0, 15));
        items++;
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (pending_requests.size() > 0 || in_valid || expected_verdicts.size() > 0)
      @(posedge clk);
    // A last load may still be going in; allow a classify's worth of time.
    repeat (1500) @(posedge clk);
    if (mismatch_count == 0 && expected_verdicts.size() == 0)
      $display("cosine_nearest_centroid_classifier_test: clean");
    else
      $display("cosine_nearest_centroid_classifier_test: errors");
    $finish;
  end

  initial begin
    #10ms;
    $display("cosine_nearest_centroid_classifier_test: errors");
    $finish;
  end

endmodule
